// File: sv/dscww_pkg.sv
// ----------------------------------------------------------------------------
// dscww_pkg
// Types and codes shared by the display command window writer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dscww_pkg;

  localparam int STORE_ADDR_W = 17;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] OP_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] OP_ROW_SET      = 8'h2B;
  localparam logic [7:0] OP_MEMORY_WRITE = 8'h2C;
  localparam logic [7:0] OP_MEMORY_MODE  = 8'h36;
  localparam logic [7:0] OP_RAM_CONTROL  = 8'hB0;
  localparam int         FLAG_BIT        = 3;

  typedef struct packed {
    logic       is_command;
    logic [7:0] byte_value;
  } spi_word_t;

  typedef struct packed {
    logic [STORE_ADDR_W-1:0] store_address;
    logic [15:0]             pixel_value;
  } store_write_t;

  typedef enum logic [2:0] {
    K_COL_START   = 3'd0,
    K_COL_STOP    = 3'd1,
    K_ROW_START   = 3'd2,
    K_ROW_STOP    = 3'd3,
    K_MODE        = 3'd4,
    K_RAMCTL      = 3'd5,
    K_WRITE_START = 3'd6,
    K_PIXEL       = 3'd7
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t kind;
    logic [15:0] data;
  } entry_t;

endpackage

`default_nettype wire

// File: sv/dscww_front.sv
// ----------------------------------------------------------------------------
// dscww_front
// Command parser: pairs argument and pixel bytes and queues window, mode,
// RAM-control, write-start and pixel operations for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dscww_front
  import dscww_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire spi_word_t word,
  output logic           push,
  output entry_t         push_entry
);

  typedef enum logic [5:0] {
    CMD_IDLE    = 6'b000001,
    CMD_COLUMNS = 6'b000010,
    CMD_ROWS    = 6'b000100,
    CMD_MODE    = 6'b001000,
    CMD_RAMCTL  = 6'b010000,
    CMD_WRITE   = 6'b100000
  } cmd_t;

  cmd_t        cmd;
  cmd_t        cmd_next;
  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic [7:0]  held;
  logic [7:0]  held_next;
  logic [15:0] pair;

  assign pair = {held, word.byte_value};

  always_comb begin
    cmd_next        = cmd;
    phase_next      = phase;
    held_next       = held;
    push            = 1'b0;
    push_entry.kind = K_PIXEL;
    push_entry.data = pair;
    if (accept) begin
      if (word.is_command) begin
        phase_next = 2'd0;
        unique case (word.byte_value)
          OP_COLUMN_SET:  cmd_next = CMD_COLUMNS;
          OP_ROW_SET:     cmd_next = CMD_ROWS;
          OP_MEMORY_MODE: cmd_next = CMD_MODE;
          OP_RAM_CONTROL: cmd_next = CMD_RAMCTL;
          OP_MEMORY_WRITE: begin
            cmd_next        = CMD_WRITE;
            push            = 1'b1;
            push_entry.kind = K_WRITE_START;
          end
          default:        cmd_next = CMD_IDLE;
        endcase
      end else begin
        unique case (cmd)
          CMD_COLUMNS: begin
            if (phase == 2'd0 || phase == 2'd2) begin
              held_next  = word.byte_value;
              phase_next = phase + 2'd1;
            end else if (phase == 2'd1) begin
              push            = 1'b1;
              push_entry.kind = K_COL_START;
              phase_next      = 2'd2;
            end else begin
              push            = 1'b1;
              push_entry.kind = K_COL_STOP;
              cmd_next        = CMD_IDLE;
              phase_next      = 2'd0;
            end
          end
          CMD_ROWS: begin
            if (phase == 2'd0 || phase == 2'd2) begin
              held_next  = word.byte_value;
              phase_next = phase + 2'd1;
            end else if (phase == 2'd1) begin
              push            = 1'b1;
              push_entry.kind = K_ROW_START;
              phase_next      = 2'd2;
            end else begin
              push            = 1'b1;
              push_entry.kind = K_ROW_STOP;
              cmd_next        = CMD_IDLE;
              phase_next      = 2'd0;
            end
          end
          CMD_MODE: begin
            push            = 1'b1;
            push_entry.kind = K_MODE;
            cmd_next        = CMD_IDLE;
          end
          CMD_RAMCTL: begin
            if (phase == 2'd0) begin
              phase_next = 2'd1;
            end else begin
              push            = 1'b1;
              push_entry.kind = K_RAMCTL;
              cmd_next        = CMD_IDLE;
              phase_next      = 2'd0;
            end
          end
          CMD_WRITE: begin
            if (phase == 2'd0) begin
              held_next  = word.byte_value;
              phase_next = 2'd1;
            end else begin
              push            = 1'b1;
              push_entry.kind = K_PIXEL;
              phase_next      = 2'd0;
            end
          end
          CMD_IDLE:    cmd_next = CMD_IDLE;
          default:     cmd_next = CMD_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd   <= CMD_IDLE;
      phase <= 2'd0;
      held  <= 8'd0;
    end else begin
      cmd   <= cmd_next;
      phase <= phase_next;
      held  <= held_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/dscww_queue.sv
// ----------------------------------------------------------------------------
// dscww_queue
// Short first-in first-out queue of parsed operations between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dscww_queue
  import dscww_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output entry_t      pop_entry,
  output logic        empty
);

  entry_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QUEUE_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QUEUE_PTR_W + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/dscww_back.sv
// ----------------------------------------------------------------------------
// dscww_back
// Window state and write position; turns queued pixels into frame-store
// writes held in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dscww_back
  import dscww_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   empty,
  input  wire entry_t entry,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output store_write_t out_data
);

  localparam int XW         = $clog2(SCREEN_WIDTH + 1);
  localparam int YW         = $clog2(SCREEN_HEIGHT + 1);
  localparam int SW         = STORE_ADDR_W + 1;
  localparam int STORE_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;

  logic [XW-1:0]           win_x;
  logic [XW-1:0]           win_w;
  logic [YW-1:0]           win_y;
  logic [YW-1:0]           win_h;
  logic                    swap_rb;
  logic                    low_first;
  logic [XW-1:0]           col;
  logic [YW-1:0]           row;
  logic [STORE_ADDR_W-1:0] row_base;
  logic                    writing;

  logic [16:0]             data_ext;
  logic [16:0]             stop_end;
  logic [16:0]             x_end;
  logic [16:0]             y_end;
  logic [XW-1:0]           x_start;
  logic [YW-1:0]           y_start;
  logic [XW-1:0]           x_extent;
  logic [YW-1:0]           y_extent;
  logic [SW-1:0]           start_base;
  logic [SW-1:0]           addr;
  logic [SW-1:0]           next_base;
  logic [XW:0]             col_inc;
  logic [YW:0]             row_inc;
  logic [15:0]             px_raw;
  logic [15:0]             px;
  logic                    emit;

  assign pop = !empty && (!out_valid || !out_stall);

  assign data_ext = {1'b0, entry.data};
  assign stop_end = data_ext + 17'd1;
  assign x_end    = (stop_end > 17'(SCREEN_WIDTH)) ? 17'(SCREEN_WIDTH) : stop_end;
  assign y_end    = (stop_end > 17'(SCREEN_HEIGHT)) ? 17'(SCREEN_HEIGHT) : stop_end;
  assign x_start  = (data_ext >= 17'(SCREEN_WIDTH)) ? XW'(SCREEN_WIDTH - 1)
                                                    : XW'(entry.data);
  assign y_start  = (data_ext >= 17'(SCREEN_HEIGHT)) ? YW'(SCREEN_HEIGHT - 1)
                                                     : YW'(entry.data);
  assign x_extent = (x_end <= 17'(win_x)) ? XW'(1) : XW'(x_end - 17'(win_x));
  assign y_extent = (y_end <= 17'(win_y)) ? YW'(1) : YW'(y_end - 17'(win_y));

  assign start_base = SW'(win_y) * SW'(SCREEN_WIDTH) + SW'(win_x);
  assign addr       = SW'(row_base) + SW'(col);
  assign next_base  = SW'(row_base) + SW'(SCREEN_WIDTH);
  assign col_inc    = {1'b0, col} + (XW + 1)'(1);
  assign row_inc    = {1'b0, row} + (YW + 1)'(1);

  assign px_raw = low_first ? {entry.data[7:0], entry.data[15:8]} : entry.data;
  assign px     = swap_rb ? {px_raw[4:0], px_raw[10:5], px_raw[15:11]} : px_raw;
  assign emit   = pop && (entry.kind == K_PIXEL) && writing
                  && (addr < SW'(STORE_SIZE));

  always_ff @(posedge clk) begin
    if (rst) begin
      win_x     <= '0;
      win_w     <= XW'(SCREEN_WIDTH);
      win_y     <= '0;
      win_h     <= YW'(SCREEN_HEIGHT);
      swap_rb   <= 1'b0;
      low_first <= 1'b0;
      col       <= '0;
      row       <= '0;
      row_base  <= '0;
      writing   <= 1'b0;
    end else if (pop) begin
      unique case (entry.kind)
        K_COL_START: win_x <= x_start;
        K_COL_STOP:  win_w <= x_extent;
        K_ROW_START: win_y <= y_start;
        K_ROW_STOP:  win_h <= y_extent;
        K_MODE:      swap_rb <= entry.data[FLAG_BIT];
        K_RAMCTL:    low_first <= entry.data[FLAG_BIT];
        K_WRITE_START: begin
          writing <= 1'b1;
          col     <= '0;
          row     <= '0;
          if (start_base > SW'(STORE_SIZE)) begin
            row_base <= STORE_ADDR_W'(STORE_SIZE);
          end else begin
            row_base <= STORE_ADDR_W'(start_base);
          end
        end
        K_PIXEL: begin
          if (writing) begin
            if (col_inc >= (XW + 1)'(win_w)) begin
              col <= '0;
              if (next_base > SW'(STORE_SIZE)) begin
                row_base <= STORE_ADDR_W'(STORE_SIZE);
              end else begin
                row_base <= STORE_ADDR_W'(next_base);
              end
              if (row_inc >= (YW + 1)'(win_h)) begin
                writing <= 1'b0;
                row     <= '0;
              end else begin
                row <= YW'(row_inc);
              end
            end else begin
              col <= XW'(col_inc);
            end
          end
        end
        default: writing <= writing;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.store_address <= STORE_ADDR_W'(addr);
      out_data.pixel_value   <= px;
    end
  end

endmodule

`default_nettype wire

// File: sv/display_spi_command_window_writer.sv
// ----------------------------------------------------------------------------
// display_spi_command_window_writer
// Turns a stream of SPI display words into RGB565 frame-store writes.
//
// spi channel: one 9-bit word per beat (command flag and byte). Column-set,
// row-set, memory-mode and RAM-control words update the draw window and
// pixel format; memory-write data pairs become pixel writes.
// store channel: one beat per pixel, word address and RGB565 value, written
// row by row within the window. Writes past the frame store are dropped.
// Throughput is one spi beat per cycle while spi_stall is low. A pixel passes
// through the operation queue and then the window/address unit, which loads
// the output register; the parser pushes each operation into the queue directly.
// A stall on the store channel holds the output register; the four-entry
// operation queue keeps absorbing spi beats until it fills, then spi_stall
// rises. Reset idles the parser, empties the queue, restores a full-screen
// window with normal byte order and no red/blue swap, and drops any pending
// output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module display_spi_command_window_writer
  import dscww_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      spi_valid,
  output logic           spi_stall,
  input  wire spi_word_t spi_word,
  output logic           store_valid,
  input  wire logic      store_stall,
  output store_write_t   store_write
);

  logic   accept;
  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  entry_t pop_entry;
  logic   empty;

  assign spi_stall = full;
  assign accept    = spi_valid && !full;

  dscww_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .word       (spi_word),
    .push       (push),
    .push_entry (push_entry)
  );

  dscww_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (empty)
  );

  dscww_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .entry     (pop_entry),
    .pop       (pop),
    .out_valid (store_valid),
    .out_stall (store_stall),
    .out_data  (store_write)
  );

endmodule

`default_nettype wire

// File: verif/window_write_checker.sv
// ----------------------------------------------------------------------------
// window_write_checker
// Watches the spi and store channels of the display command window writer.
// Every accepted spi beat runs through a cycle-free model of the command
// parser, window arithmetic and pixel packing. Each pixel write that the
// model expects is queued, and every accepted store beat is compared field
// by field with the oldest queued write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module window_write_checker
  import dscww_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         spi_valid,
  input  logic         spi_stall,
  input  spi_word_t    spi_word,
  input  logic         store_valid,
  input  logic         store_stall,
  input  store_write_t store_write,
  output int           mismatch_count,
  output int           pending_writes,
  output int           checked_writes
);

  localparam int STORE_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;

  typedef enum logic [5:0] {
    CMD_IDLE    = 6'b000001,
    CMD_COLUMNS = 6'b000010,
    CMD_ROWS    = 6'b000100,
    CMD_MODE    = 6'b001000,
    CMD_RAMCTL  = 6'b010000,
    CMD_WRITE   = 6'b100000
  } command_t;

  command_t     cur_cmd;
  logic [1:0]   arg_phase;
  logic [7:0]   first_byte;
  logic [8:0]   win_x;
  logic [8:0]   win_w;
  logic [7:0]   win_y;
  logic [7:0]   win_h;
  logic         swap_rb;
  logic         little_endian;
  logic [8:0]   col;
  logic [7:0]   row;
  logic [16:0]  row_base;
  store_write_t expected_writes[$];
  store_write_t oldest;

  initial begin
    mismatch_count = 0;
    pending_writes = 0;
    checked_writes = 0;
  end

  function automatic int clamped_start(input int v, input int size);
    return (v >= size) ? size - 1 : v;
  endfunction

  function automatic int window_extent(input int stop, input int start, input int size);
    int last;
    last = stop + 1;
    if (last > size) last = size;
    if (last <= start) return 1;
    return last - start;
  endfunction

  task automatic clear_window_state();
    cur_cmd       = CMD_IDLE;
    arg_phase     = '0;
    first_byte    = '0;
    win_x         = '0;
    win_w         = 9'(SCREEN_WIDTH);
    win_y         = '0;
    win_h         = 8'(SCREEN_HEIGHT);
    swap_rb       = 1'b0;
    little_endian = 1'b0;
    col           = '0;
    row           = '0;
    row_base      = '0;
    expected_writes.delete();
  endtask

  task automatic predict_beat(input spi_word_t w);
    logic [7:0]  b;
    logic [15:0] pair;
    logic [15:0] px;
    int          addr;
    b    = w.byte_value;
    pair = {first_byte, b};
    if (w.is_command) begin
      arg_phase = '0;
      case (b)
        OP_COLUMN_SET:  cur_cmd = CMD_COLUMNS;
        OP_ROW_SET:     cur_cmd = CMD_ROWS;
        OP_MEMORY_MODE: cur_cmd = CMD_MODE;
        OP_RAM_CONTROL: cur_cmd = CMD_RAMCTL;
        OP_MEMORY_WRITE: begin
          cur_cmd  = CMD_WRITE;
          col      = '0;
          row      = '0;
          addr     = int'(win_y) * SCREEN_WIDTH + int'(win_x);
          row_base = (addr > STORE_SIZE) ? 17'(STORE_SIZE) : 17'(addr);
        end
        default:        cur_cmd = CMD_IDLE;
      endcase
    end else begin
      case (cur_cmd) inside
        CMD_COLUMNS, CMD_ROWS: begin
          if (arg_phase == 2'd0 || arg_phase == 2'd2) begin
            first_byte = b;
            arg_phase  = arg_phase + 2'd1;
          end else if (arg_phase == 2'd1) begin
            if (cur_cmd == CMD_COLUMNS)
              win_x = 9'(clamped_start(int'(pair), SCREEN_WIDTH));
            else
              win_y = 8'(clamped_start(int'(pair), SCREEN_HEIGHT));
            arg_phase = 2'd2;
          end else begin
            if (cur_cmd == CMD_COLUMNS)
              win_w = 9'(window_extent(int'(pair), int'(win_x), SCREEN_WIDTH));
            else
              win_h = 8'(window_extent(int'(pair), int'(win_y), SCREEN_HEIGHT));
            cur_cmd   = CMD_IDLE;
            arg_phase = '0;
          end
        end
        CMD_MODE: begin
          swap_rb = b[FLAG_BIT];
          cur_cmd = CMD_IDLE;
        end
        CMD_RAMCTL: begin
          if (arg_phase == 2'd0) begin
            arg_phase = 2'd1;
          end else begin
            little_endian = b[FLAG_BIT];
            cur_cmd       = CMD_IDLE;
            arg_phase     = '0;
          end
        end
        CMD_WRITE: begin
          if (arg_phase == 2'd0) begin
            first_byte = b;
            arg_phase  = 2'd1;
          end else begin
            arg_phase = '0;
            px = little_endian ? {b, first_byte} : pair;
            if (swap_rb) px = {px[4:0], px[10:5], px[15:11]};
            addr = int'(row_base) + int'(col);
            if (addr < STORE_SIZE)
              expected_writes.push_back('{store_address: addr[16:0], pixel_value: px});
            col = col + 9'd1;
            if (col >= win_w) begin
              col      = '0;
              row      = row + 8'd1;
              addr     = int'(row_base) + SCREEN_WIDTH;
              row_base = (addr > STORE_SIZE) ? 17'(STORE_SIZE) : 17'(addr);
              if (row >= win_h) begin
                cur_cmd = CMD_IDLE;
                row     = '0;
              end
            end
          end
        end
        default: cur_cmd = CMD_IDLE;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_window_state();
    end else begin
      if (store_valid && !store_stall) begin
        if (expected_writes.size() == 0) begin
          $error("store beat with no pixel write pending: address %0d pixel %h",
                 store_write.store_address, store_write.pixel_value);
          mismatch_count++;
        end else begin
          oldest = expected_writes.pop_front();
          checked_writes++;
          if (store_write.store_address !== oldest.store_address) begin
            $error("store_address mismatch: expected %0d, actual %0d",
                   oldest.store_address, store_write.store_address);
            mismatch_count++;
          end
          if (store_write.pixel_value !== oldest.pixel_value) begin
            $error("pixel_value mismatch: expected %h, actual %h",
                   oldest.pixel_value, store_write.pixel_value);
            mismatch_count++;
          end
        end
      end
      if (spi_valid && !spi_stall) predict_beat(spi_word);
    end
    pending_writes = expected_writes.size();
  end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the display command window writer.
// A short directed run covers stray data, pixel packing with both byte
// orders and red/blue swap, start clamping, a stale extent running past the
// frame store and unknown opcodes. Random command sequences with small
// windows, pixel bursts and some broken or noise traffic follow, under
// several mixes of sender gaps and receiver stalls. A separate checker
// predicts and compares every store beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import dscww_pkg::*;

  localparam int SCREEN_WIDTH   = 320;
  localparam int SCREEN_HEIGHT  = 240;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int MIX_COUNT      = 4;
  localparam int ROUNDS         = 2;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         spi_valid = 1'b0;
  logic         spi_stall;
  spi_word_t    spi_word = '0;
  logic         store_valid;
  logic         store_stall = 1'b0;
  store_write_t store_write;

  int mismatch_count;
  int pending_writes;
  int checked_writes;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int beats_sent = 0;
  int noise_beats = 0;
  int idle_cycles = 0;

  const int idle_plan[MIX_COUNT]  = '{0, 82, 0, 19};
  const int stall_plan[MIX_COUNT] = '{0, 0, 82, 19};

  always #6 clk = ~clk;

  display_spi_command_window_writer #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .spi_valid  (spi_valid),
    .spi_stall  (spi_stall),
    .spi_word   (spi_word),
    .store_valid(store_valid),
    .store_stall(store_stall),
    .store_write(store_write)
  );

  window_write_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .spi_valid     (spi_valid),
    .spi_stall     (spi_stall),
    .spi_word      (spi_word),
    .store_valid   (store_valid),
    .store_stall   (store_stall),
    .store_write   (store_write),
    .mismatch_count(mismatch_count),
    .pending_writes(pending_writes),
    .checked_writes(checked_writes)
  );

  always @(negedge clk) begin
    store_stall <= (recv_stall_pct > 0) && (int'($urandom_range(99)) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (spi_valid && !spi_stall) || (store_valid && !store_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic cmd, input logic [7:0] value);
    while (send_idle_pct > 0 && int'($urandom_range(99)) < send_idle_pct) begin
      spi_valid = 1'b0;
      @(negedge clk);
    end
    spi_valid = 1'b1;
    spi_word  = '{is_command: cmd, byte_value: value};
    @(posedge clk);
    while (spi_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain_writes();
    spi_valid = 1'b0;
    while (pending_writes != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_start(input int size);
    case ($urandom_range(7))
      0:       return 16'($urandom_range(65535));
      1:       return 16'(size - 1 - int'($urandom_range(3)));
      2:       return 16'(size + int'($urandom_range(3)));
      default: return 16'($urandom_range(size - 1));
    endcase
  endfunction

  function automatic logic [15:0] pick_stop(input logic [15:0] start, input int size);
    case ($urandom_range(7))
      0:       return 16'($urandom_range(65535));
      1:       return start - 16'($urandom_range(3));
      2:       return 16'(size - 1 + int'($urandom_range(2)));
      default: return start + 16'($urandom_range(7));
    endcase
  endfunction

  // start pair then stop pair, sometimes cut short
  task automatic send_window(input logic [7:0] op, input int size);
    logic [15:0] start_val;
    logic [15:0] stop_val;
    logic [7:0]  args[4];
    int          keep;
    start_val = pick_start(size);
    stop_val  = pick_stop(start_val, size);
    args      = '{start_val[15:8], start_val[7:0], stop_val[15:8], stop_val[7:0]};
    keep      = ($urandom_range(6) == 0) ? int'($urandom_range(3)) : 4;
    send_word(1'b1, op);
    for (int i = 0; i < keep; i++) send_word(1'b0, args[i]);
  endtask

  task automatic send_pixels();
    int count;
    count = ($urandom_range(9) == 0) ? int'($urandom_range(40, 90))
                                     : int'($urandom_range(1, 20));
    count = 2 * count + (($urandom_range(7) == 0) ? 1 : 0);
    send_word(1'b1, OP_MEMORY_WRITE);
    for (int i = 0; i < count; i++) send_word(1'b0, 8'($urandom_range(255)));
  endtask

  task automatic send_random_sequence();
    int n;
    case ($urandom_range(19)) inside
      [0:3]: send_window(OP_COLUMN_SET, SCREEN_WIDTH);
      [4:7]: send_window(OP_ROW_SET, SCREEN_HEIGHT);
      8: begin
        send_word(1'b1, OP_MEMORY_MODE);
        send_word(1'b0, 8'($urandom_range(255)));
      end
      9: begin
        send_word(1'b1, OP_RAM_CONTROL);
        send_word(1'b0, 8'($urandom_range(255)));
        if ($urandom_range(5) != 0) send_word(1'b0, 8'($urandom_range(255)));
      end
      17: begin
        n = int'($urandom_range(1, 3));
        for (int i = 0; i < n; i++) send_word(1'b0, 8'($urandom_range(255)));
        noise_beats += n;
      end
      [18:19]: begin
        n = int'($urandom_range(0, 3));
        send_word(1'b1, 8'($urandom_range(255)));
        for (int i = 0; i < n; i++) send_word(1'b0, 8'($urandom_range(255)));
        noise_beats += n + 1;
      end
      default: send_pixels();
    endcase
  endtask

  initial begin
    int failures;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // stray data, then two full-screen pixels
    send_word(1'b0, 8'hFF);
    send_word(1'b1, OP_MEMORY_WRITE);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hFF);
    // red/blue swap and low byte first
    send_word(1'b1, OP_MEMORY_MODE);
    send_word(1'b0, 8'h08);
    send_word(1'b1, OP_RAM_CONTROL);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'h08);
    // start past the right edge clamps, one column wide
    send_word(1'b1, OP_COLUMN_SET);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'hFF);
    // last row start only, stale height runs past the frame store
    send_word(1'b1, OP_ROW_SET);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hEF);
    send_word(1'b1, OP_MEMORY_WRITE);
    send_word(1'b0, 8'hF8);
    send_word(1'b0, 8'h1F);
    send_word(1'b0, 8'h07);
    send_word(1'b0, 8'hE0);
    // unknown opcode swallows its data
    send_word(1'b1, 8'h00);
    send_word(1'b0, 8'h55);
    drain_writes();

    for (int r = 0; r < ROUNDS; r++) begin
      for (int m = 0; m < MIX_COUNT; m++) begin
        int target;
        send_idle_pct  = idle_plan[m];
        recv_stall_pct = stall_plan[m];
        target = (beats_sent - noise_beats) + RANDOM_ITEMS / (ROUNDS * MIX_COUNT);
        while (beats_sent - noise_beats < target) send_random_sequence();
        drain_writes();
      end
    end

    drain_writes();
    repeat (SETTLE_CYCLES) @(negedge clk);
    failures = mismatch_count + pending_writes;
    $display("covered %0d spi beats and %0d checked pixel writes", beats_sent, checked_writes);
    $display("under four gap/stall mixes, two rounds each");
    if (failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
sv/dscww_pkg.sv
sv/dscww_front.sv
sv/dscww_queue.sv
sv/dscww_back.sv
sv/display_spi_command_window_writer.sv
verif/window_write_checker.sv
verif/tb.sv
